### hw/rtl/spkt_pkg.sv
// spkt_pkg: shared types, codes and the row compare for the sorted pair key table
// no dependencies

package spkt_pkg;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_SORT   = 2'd1,
      OP_FIND   = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NOT_FOUND = 3'd1,
      ST_UNSORTED  = 3'd2,
      ST_FULL      = 3'd3,
      ST_SKIPPED   = 3'd4
   } status_type;

   localparam logic [1:0] VK_INT    = 2'd0;
   localparam logic [1:0] VK_STRING = 2'd1;

   typedef struct packed {
      logic signed [31:0] owner;
      logic signed [31:0] key;
      logic signed [31:0] value;
      logic               mark;
   } row_type;

   typedef enum logic [1:0] {
      WSEL_REQ = 2'd0,
      WSEL_A   = 2'd1,
      WSEL_B   = 2'd2
   } wsel_type;

   typedef struct packed {
      logic     wr_en;
      logic     wr_bank;
      wsel_type wr_sel;
      logic     rd_bank;
      logic     load_query;
   } cmd_type;

   typedef struct packed {
      row_type row_a;
      logic    b_lt_a;
      logic    a_lt_q;
      logic    q_lt_a;
   } stat_type;

   function automatic logic pair_lt(input logic signed [31:0] o1, input logic signed [31:0] k1,
                                    input logic signed [31:0] o2, input logic signed [31:0] k2);
      pair_lt = (o1 < o2) || ((o1 == o2) && (k1 < k2));
   endfunction

endpackage

### hw/rtl/spkt_req_if.sv
// spkt_req_if: request channel, valid/ready with the operation payload
// depends on spkt_pkg

interface spkt_req_if;
   import spkt_pkg::*;
   logic               valid;
   logic               ready;
   op_type             kind;
   logic signed [31:0] owner;
   logic signed [31:0] param_key;
   logic signed [31:0] value;
   logic [1:0]         value_kind;
   logic               value_present;

   modport source(output valid, kind, owner, param_key, value, value_kind, value_present,
                  input ready);
   modport sink(input valid, kind, owner, param_key, value, value_kind, value_present,
                output ready);
endinterface

### hw/rtl/spkt_rsp_if.sv
// spkt_rsp_if: response channel, valid/ready with status and found row data
// depends on spkt_pkg

interface spkt_rsp_if;
   import spkt_pkg::*;
   logic               valid;
   logic               ready;
   status_type         status;
   logic signed [31:0] found_value;
   logic               found_is_string;

   modport source(output valid, status, found_value, found_is_string, input ready);
   modport sink(input valid, status, found_value, found_is_string, output ready);
endinterface

### hw/rtl/spkt_dpath.sv
// spkt_dpath: two row banks, query register and the row compares
// depends on spkt_pkg

module spkt_dpath #(
   parameter int TABLE_DEPTH = 4096,
   parameter int AW = 12
) (
   input  logic               clock,
   input  spkt_pkg::cmd_type  cmd,
   input  logic [AW-1:0]      wr_addr,
   input  logic [AW-1:0]      rd_addr_a,
   input  logic [AW-1:0]      rd_addr_b,
   input  logic signed [31:0] req_owner,
   input  logic signed [31:0] req_key,
   input  logic signed [31:0] req_value,
   input  logic [1:0]         req_value_kind,
   output spkt_pkg::stat_type st
);
   import spkt_pkg::*;

   row_type mem0_ff [TABLE_DEPTH];
   row_type mem1_ff [TABLE_DEPTH];
   row_type a0_ff, a1_ff, b0_ff, b1_ff;
   logic    bank_ff;
   logic signed [31:0] q_owner_ff, q_key_ff;
   row_type req_row, row_a, row_b, wr_row;

   always_comb begin
      req_row.owner = req_owner;
      req_row.key   = req_key;
      req_row.mark  = (req_value_kind == VK_STRING);
      req_row.value = (req_value_kind == VK_STRING) ? 32'sd0 : req_value;
      row_a = bank_ff ? a1_ff : a0_ff;
      row_b = bank_ff ? b1_ff : b0_ff;
      case (cmd.wr_sel)
         WSEL_REQ: wr_row = req_row;
         WSEL_A:   wr_row = row_a;
         WSEL_B:   wr_row = row_b;
         default:  wr_row = req_row;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en && !cmd.wr_bank) mem0_ff[wr_addr] <= wr_row;
      if (cmd.wr_en && cmd.wr_bank)  mem1_ff[wr_addr] <= wr_row;
      a0_ff   <= mem0_ff[rd_addr_a];
      b0_ff   <= mem0_ff[rd_addr_b];
      a1_ff   <= mem1_ff[rd_addr_a];
      b1_ff   <= mem1_ff[rd_addr_b];
      bank_ff <= cmd.rd_bank;
      if (cmd.load_query) begin
         q_owner_ff <= req_owner;
         q_key_ff   <= req_key;
      end
   end

   assign st = '{row_a,
                 pair_lt(row_b.owner, row_b.key, row_a.owner, row_a.key),
                 pair_lt(row_a.owner, row_a.key, q_owner_ff, q_key_ff),
                 pair_lt(q_owner_ff, q_key_ff, row_a.owner, row_a.key)};

endmodule

### hw/rtl/spkt_ctrl.sv
// spkt_ctrl: sequencer for insert, merge sort, binary search and clear, plus result register
// depends on spkt_pkg and the channel interfaces

module spkt_ctrl #(
   parameter int TABLE_DEPTH = 4096,
   parameter int AW = 12
) (
   input  logic               clock,
   input  logic               reset,
   spkt_req_if.sink           req_chan,
   spkt_rsp_if.source         rsp_chan,
   input  spkt_pkg::stat_type st,
   output spkt_pkg::cmd_type  cmd,
   output logic [AW-1:0]      wr_addr,
   output logic [AW-1:0]      rd_addr_a,
   output logic [AW-1:0]      rd_addr_b
);
   import spkt_pkg::*;

   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int XW = CW + 1;
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

   typedef enum logic [2:0] {
      S_IDLE, S_FRD, S_FCMP, S_BLK, S_MRD, S_MWR, S_RESP
   } state_type;

   state_type          state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic               sorted_ff, sorted_in, cur_ff, cur_in;
   logic [XW-1:0]      lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic [XW-1:0]      p_ff, p_in, q_ff, q_in, o_ff, o_in, w_ff, w_in;
   status_type         res_st_ff, res_st_in;
   logic signed [31:0] res_val_ff, res_val_in;
   logic               res_str_ff, res_str_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_st_ff, rsp_st_in;
   logic signed [31:0] rsp_val_ff, rsp_val_in;
   logic               rsp_str_ff, rsp_str_in;

   logic          accept, take_b, p_live, q_live;
   logic [XW-1:0] n_x, fmid, bmid, bhi, lo_next, w_next;

   assign n_x    = XW'(count_ff);
   assign accept = req_chan.valid && req_chan.ready;
   assign p_live = p_ff < mid_ff;
   assign q_live = q_ff < hi_ff;
   assign take_b = q_live && (!p_live || st.b_lt_a);
   assign fmid   = lo_ff + ((hi_ff - lo_ff - XW'(1)) >> 1);
   assign bmid   = ((lo_ff + w_ff) < n_x) ? (lo_ff + w_ff) : n_x;
   assign bhi    = ((bmid + w_ff) < n_x) ? (bmid + w_ff) : n_x;
   assign lo_next = lo_ff + (w_ff << 1);
   assign w_next  = w_ff << 1;

   assign req_chan.ready           = (state_ff == S_IDLE);
   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.status          = rsp_st_ff;
   assign rsp_chan.found_value     = rsp_val_ff;
   assign rsp_chan.found_is_string = rsp_str_ff;

   always_comb begin
      state_in = state_ff;   count_in = count_ff; sorted_in = sorted_ff; cur_in = cur_ff;
      lo_in = lo_ff; hi_in = hi_ff; mid_in = mid_ff;
      p_in = p_ff; q_in = q_ff; o_in = o_ff; w_in = w_ff;
      res_st_in = res_st_ff; res_val_in = res_val_ff; res_str_in = res_str_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_st_in = rsp_st_ff; rsp_val_in = rsp_val_ff; rsp_str_in = rsp_str_ff;
      cmd.wr_en = 1'b0;
      cmd.wr_bank = cur_ff;
      cmd.wr_sel = WSEL_REQ;
      cmd.rd_bank = cur_ff;
      cmd.load_query = accept;
      wr_addr   = count_ff[AW-1:0];
      rd_addr_a = p_ff[AW-1:0];
      rd_addr_b = q_ff[AW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_st_in = ST_OK; res_val_in = 32'sd0; res_str_in = 1'b0;
               state_in = S_RESP;
               case (req_chan.kind)
                  OP_INSERT: begin
                     sorted_in = 1'b0;
                     if (!req_chan.value_present ||
                         (req_chan.value_kind != VK_INT && req_chan.value_kind != VK_STRING))
                     begin
                        res_st_in = ST_SKIPPED;
                     end else if (count_ff >= DEPTH_C) begin
                        res_st_in = ST_FULL;
                     end else begin
                        cmd.wr_en = 1'b1;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  OP_SORT: begin
                     sorted_in = 1'b1;
                     if (count_ff > CW'(1)) begin
                        lo_in = '0; w_in = XW'(1); state_in = S_BLK;
                     end
                  end
                  OP_FIND: begin
                     if (count_ff == '0) res_st_in = ST_NOT_FOUND;
                     else if (!sorted_ff) res_st_in = ST_UNSORTED;
                     else begin
                        lo_in = '0; hi_in = n_x; state_in = S_FRD;
                     end
                  end
                  default: begin
                     count_in = '0; sorted_in = 1'b0;
                  end
               endcase
            end
         end
         S_FRD: begin
            rd_addr_a = fmid[AW-1:0];
            mid_in = fmid;
            if (lo_ff < hi_ff) state_in = S_FCMP;
            else begin
               res_st_in = ST_NOT_FOUND; state_in = S_RESP;
            end
         end
         S_FCMP: begin
            if (st.a_lt_q) begin
               lo_in = mid_ff + XW'(1); state_in = S_FRD;
            end else if (st.q_lt_a) begin
               hi_in = mid_ff; state_in = S_FRD;
            end else begin
               res_val_in = st.row_a.value; res_str_in = st.row_a.mark; state_in = S_RESP;
            end
         end
         S_BLK: begin
            mid_in = bmid; hi_in = bhi; p_in = lo_ff; q_in = bmid; o_in = lo_ff;
            state_in = S_MRD;
         end
         S_MRD: begin
            if (p_live || q_live) state_in = S_MWR;
            else if (lo_next < n_x) begin
               lo_in = lo_next; state_in = S_BLK;
            end else begin
               cur_in = !cur_ff;
               if (w_next < n_x) begin
                  w_in = w_next; lo_in = '0; state_in = S_BLK;
               end else state_in = S_RESP;
            end
         end
         S_MWR: begin
            cmd.wr_en = 1'b1;
            cmd.wr_bank = !cur_ff;
            cmd.wr_sel = take_b ? WSEL_B : WSEL_A;
            wr_addr = o_ff[AW-1:0];
            o_in = o_ff + XW'(1);
            if (take_b) q_in = q_ff + XW'(1);
            else p_in = p_ff + XW'(1);
            state_in = S_MRD;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_st_in = res_st_ff; rsp_val_in = res_val_ff; rsp_str_in = res_str_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         sorted_ff <= 1'b0;
         cur_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         sorted_ff <= sorted_in;
         cur_ff <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lo_ff <= lo_in; hi_ff <= hi_in; mid_ff <= mid_in;
      p_ff <= p_in; q_ff <= q_in; o_ff <= o_in; w_ff <= w_in;
      res_st_ff <= res_st_in; res_val_ff <= res_val_in; res_str_ff <= res_str_in;
      rsp_st_ff <= rsp_st_in; rsp_val_ff <= rsp_val_in; rsp_str_ff <= rsp_str_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C) else $error("row count beyond table depth");
   a_merge_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MWR |-> o_ff < n_x) else $error("merge write outside table");
   a_clear: assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.kind == OP_CLEAR |=> count_ff == '0 && !sorted_ff)
      else $error("clear left rows");
   a_find_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FCMP |-> mid_ff < n_x) else $error("search probe outside table");

endmodule

### hw/rtl/sorted_pair_key_table_top.sv
// sorted_pair_key_table_top: top level joining the controller and the row bank datapath
// depends on spkt_pkg, spkt_req_if, spkt_rsp_if, spkt_ctrl, spkt_dpath

// One transaction is taken at a time. Insert and clear pass straight to the response
// state; find takes a read state and a compare state per search probe and one more
// read when the key is absent; sort is a stable bottom-up merge between two row
// banks, with a read state and a write state for each row of each pass and a setup
// state for each block. A finished result waits in an output register while the next
// transaction is taken.
module sorted_pair_key_table_top #(
   parameter int TABLE_DEPTH = 4096
) (
   input logic        clock,
   input logic        reset,
   spkt_req_if.sink   req_chan,
   spkt_rsp_if.source rsp_chan
);
   import spkt_pkg::*;

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   cmd_type       cmd;
   stat_type      st;
   logic [AW-1:0] wr_addr, rd_addr_a, rd_addr_b;

   spkt_ctrl #(.TABLE_DEPTH(TABLE_DEPTH), .AW(AW)) u_ctrl (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .st(st), .cmd(cmd), .wr_addr(wr_addr), .rd_addr_a(rd_addr_a), .rd_addr_b(rd_addr_b)
   );

   spkt_dpath #(.TABLE_DEPTH(TABLE_DEPTH), .AW(AW)) u_dpath (
      .clock(clock), .cmd(cmd), .wr_addr(wr_addr), .rd_addr_a(rd_addr_a),
      .rd_addr_b(rd_addr_b), .req_owner(req_chan.owner), .req_key(req_chan.param_key),
      .req_value(req_chan.value), .req_value_kind(req_chan.value_kind), .st(st)
   );

endmodule
